/* rtl/ppsb_pkg.sv */
package ppsb_pkg;

  // Default window limit and derived widths of fixed fields
  localparam int WINDOW_MAX_DEFAULT = 4096;
  localparam int RAW_W              = 32;
  localparam int SAMPLE_W           = 12;
  localparam int SAMPLE_LSB         = 2;
  localparam int WIN_SIZE_W         = 13;
  localparam int CFG_INDEX_W        = 4;
  localparam int OUT_DATA_W         = 32;

  localparam logic [SAMPLE_W-1:0]   SAMPLE_MASK      = 12'h0FFF;
  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET   = 13'd1024;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_SAMPLE      = 2'd0,
    REQ_CLEAR_PING  = 2'd1,
    REQ_CLEAR_PONG  = 2'd2,
    REQ_CLEAR_OVR   = 2'd3
  } req_t;

  // Ready code reported with every result
  typedef enum logic [1:0] {
    RDY_NONE    = 2'd0,
    RDY_PING    = 2'd1,
    RDY_PONG    = 2'd2,
    RDY_OVERRUN = 2'd3
  } ready_code_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLING_ENABLE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIN_LEN         = 4'd1;

  // One result item
  typedef struct packed {
    logic                write_valid;
    logic                write_bank;
    logic [SAMPLE_W-1:0] write_index;
    logic [SAMPLE_W-1:0] write_sample;
    ready_code_t         ready_code;
    logic                sample_dropped;
    logic                software_overrun;
  } result_t;

endpackage

/* rtl/ping_pong_sample_buffer_control.sv */
// Each accepted request's result is registered in the output register, or in the skid entry
// while that register is held. Throughput is one request per cycle while the skid entry is empty;
// a two-entry output stage (register plus skid) keeps s_tready high while one finished result
// waits for m_tready. All flag and counter updates happen in the cycle of acceptance.
// Reset (rst, synchronous, active high) clears fill count, bank, ready, overrun and
// dropped flags, output valid bits, and sets sampling_enable 0, window length 1024.
module ping_pong_sample_buffer_control #(
  parameter int WINDOW_MAX = ppsb_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ppsb_pkg::RAW_W-1:0]         s_tdata,   // [31:0] raw_fifo_word
  input  logic [1:0]                         s_tuser,   // [1:0] req_type
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] write_bank, [12:1] write_index, [24:13] write_sample, [26:25] ready_code,
  // [27] sample_dropped, [28] software_overrun, [31:29] zero
  output logic [ppsb_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,   // [0] write_valid
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppsb_pkg::WIN_SIZE_W-1:0]    cfg_data
);

  // Fill counter width and a compare width that holds both the window length and WINDOW_MAX
  localparam int FW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = (FW + 1 > ppsb_pkg::WIN_SIZE_W) ? FW + 1 : ppsb_pkg::WIN_SIZE_W;
  localparam logic [SW-1:0] WMAX_S = SW'(WINDOW_MAX);

  // Configuration
  logic                              sampling_enable;
  logic [ppsb_pkg::WIN_SIZE_W-1:0]   win_len;

  // Block state
  logic [FW-1:0] fill_count, fill_count_next;
  logic          active_bank, active_bank_next;
  logic          ping_ready, ping_ready_next;
  logic          pong_ready, pong_ready_next;
  logic          overrun_flag, overrun_flag_next;
  logic          dropped_flag, dropped_flag_next;

  // Output register and skid stage
  ppsb_pkg::result_t out_res, skid_res, res_next;
  logic              skid_valid;

  logic          accept;
  logic          out_free;
  ppsb_pkg::req_t req;
  logic [SW-1:0] size_ext, eff_size, fill_ext, fill_inc;
  logic          bank_unread;
  logic          do_write;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign req       = ppsb_pkg::req_t'(s_tuser);

  // Effective window size, saturated at WINDOW_MAX
  assign size_ext = SW'(win_len);
  assign eff_size = (size_ext > WMAX_S) ? WMAX_S : size_ext;
  assign fill_ext = SW'(fill_count);
  assign fill_inc = fill_ext + SW'(1);
  assign bank_unread = active_bank ? pong_ready : ping_ready;
  assign do_write = (req == ppsb_pkg::REQ_SAMPLE) && !bank_unread && sampling_enable
                    && (fill_ext < eff_size);

  // Next state and result of the request at the input
  always_comb begin
    fill_count_next   = fill_count;
    active_bank_next  = active_bank;
    ping_ready_next   = ping_ready;
    pong_ready_next   = pong_ready;
    overrun_flag_next = overrun_flag;
    dropped_flag_next = dropped_flag;
    res_next          = '0;

    unique case (req)
      ppsb_pkg::REQ_SAMPLE: begin
        if (bank_unread) begin
          dropped_flag_next       = 1'b1;
          res_next.sample_dropped = 1'b1;
        end else if (do_write) begin
          res_next.write_valid  = 1'b1;
          res_next.write_bank   = active_bank;
          res_next.write_index  = fill_ext[ppsb_pkg::SAMPLE_W-1:0] & ppsb_pkg::SAMPLE_MASK;
          res_next.write_sample = s_tdata[ppsb_pkg::SAMPLE_LSB +: ppsb_pkg::SAMPLE_W]
                                  & ppsb_pkg::SAMPLE_MASK;
          fill_count_next = fill_inc[FW-1:0];
          // Window full: mark it ready and swap to the other bank
          if (fill_inc >= eff_size) begin
            if (!active_bank) ping_ready_next = 1'b1;
            else              pong_ready_next = 1'b1;
            active_bank_next = !active_bank;
            fill_count_next  = '0;
            if (active_bank ? ping_ready : pong_ready) overrun_flag_next = 1'b1;
          end
        end
      end
      ppsb_pkg::REQ_CLEAR_PING: ping_ready_next   = 1'b0;
      ppsb_pkg::REQ_CLEAR_PONG: pong_ready_next   = 1'b0;
      ppsb_pkg::REQ_CLEAR_OVR:  overrun_flag_next = 1'b0;
      default: ;
    endcase

    // Ready code from the updated flags, overrun first
    if (overrun_flag_next)    res_next.ready_code = ppsb_pkg::RDY_OVERRUN;
    else if (ping_ready_next) res_next.ready_code = ppsb_pkg::RDY_PING;
    else if (pong_ready_next) res_next.ready_code = ppsb_pkg::RDY_PONG;
    else                      res_next.ready_code = ppsb_pkg::RDY_NONE;
    res_next.software_overrun = dropped_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_enable <= 1'b0;
      win_len         <= ppsb_pkg::WIN_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ppsb_pkg::CFG_SAMPLING_ENABLE) sampling_enable <= cfg_data[0];
      else if (cfg_index == ppsb_pkg::CFG_WIN_LEN) win_len <= cfg_data;
    end
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      active_bank  <= 1'b0;
      ping_ready   <= 1'b0;
      pong_ready   <= 1'b0;
      overrun_flag <= 1'b0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      fill_count   <= fill_count_next;
      active_bank  <= active_bank_next;
      ping_ready   <= ping_ready_next;
      pong_ready   <= pong_ready_next;
      overrun_flag <= overrun_flag_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_res <= skid_res;
      else if (accept) out_res <= res_next;
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign m_tuser = out_res.write_valid;
  assign m_tdata = {3'b000, out_res.software_overrun, out_res.sample_dropped,
                    out_res.ready_code, out_res.write_sample, out_res.write_index,
                    out_res.write_bank};

  // Skid entry only exists behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without output entry");

  // Fill count stays inside the largest window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(fill_count) < WMAX_S)
    else $error("fill count beyond window limit");

  // A written sample never also reports a drop
  a_write_not_drop: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(res_next.write_valid && res_next.sample_dropped))
    else $error("write and drop in one result");

  // Software overrun is sticky until reset
  a_drop_sticky: assert property (@(posedge clk) disable iff (rst)
    dropped_flag |=> dropped_flag)
    else $error("dropped flag cleared without reset");

  // A ping clear leaves ping not ready
  a_clear_ping: assert property (@(posedge clk) disable iff (rst)
    (accept && req == ppsb_pkg::REQ_CLEAR_PING) |=> !ping_ready)
    else $error("ping ready survived a clear");

endmodule

/* tb/sv/ping_pong_sample_buffer_control_tb.sv */
module ping_pong_sample_buffer_control_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LIMIT = ppsb_pkg::WINDOW_MAX_DEFAULT;
  localparam int GAP_PCT   = 36;

  // What the driver does with the head of the stimulus queue
  typedef enum logic [1:0] {
    OP_REQ,
    OP_CFG,
    OP_HOLD
  } stim_op_t;

  typedef struct packed {
    stim_op_t                                op;
    ppsb_pkg::req_t                          kind;
    logic [ppsb_pkg::RAW_W-1:0]              raw;
    logic [ppsb_pkg::CFG_INDEX_W-1:0]        idx;
    logic [ppsb_pkg::WIN_SIZE_W-1:0]         val;
    logic                                    calm;
  } stim_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [ppsb_pkg::RAW_W-1:0]          s_tdata = '0;
  logic [1:0]                          s_tuser = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [ppsb_pkg::OUT_DATA_W-1:0]     m_tdata;
  logic                                m_tuser;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ppsb_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [ppsb_pkg::WIN_SIZE_W-1:0]     cfg_data = '0;

  stim_t             stim_q[$];
  ppsb_pkg::result_t pending_results[$];
  logic    calm_now = 1'b0;
  logic    calm_fill = 1'b0;
  int      err_cnt = 0;
  int      n_req = 0;
  int      n_res = 0;
  int      n_cfg = 0;
  int      n_writes = 0;
  int      n_drops = 0;
  int      n_overrun = 0;

  // Shadow of the block's state and registers
  logic                            smp_en;
  logic [ppsb_pkg::WIN_SIZE_W-1:0] win_size;
  logic [ppsb_pkg::WIN_SIZE_W-1:0] fill_cnt;
  logic                            act_bank;
  logic                            ping_rdy;
  logic                            pong_rdy;
  logic                            ovr;
  logic                            drop_sticky;

  ping_pong_sample_buffer_control dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Steer one request through the shadow state and return the result it should give
  function automatic ppsb_pkg::result_t steer_request(ppsb_pkg::req_t kind,
                                                      logic [ppsb_pkg::RAW_W-1:0] raw);
    ppsb_pkg::result_t r;
    logic              unread;
    int                span;
    r = '0;
    span = (int'(win_size) > WIN_LIMIT) ? WIN_LIMIT : int'(win_size);
    case (kind)
      ppsb_pkg::REQ_SAMPLE: begin
        unread = act_bank ? pong_rdy : ping_rdy;
        if (unread) begin
          // active bank not yet read: drop and remember it
          drop_sticky = 1'b1;
          r.sample_dropped = 1'b1;
        end else if (smp_en && int'(fill_cnt) < span) begin
          r.write_valid  = 1'b1;
          r.write_bank   = act_bank;
          r.write_index  = fill_cnt[ppsb_pkg::SAMPLE_W-1:0];
          r.write_sample = raw[ppsb_pkg::SAMPLE_LSB +: ppsb_pkg::SAMPLE_W];
          fill_cnt = fill_cnt + 1'b1;
          if (int'(fill_cnt) >= span) begin
            if (act_bank) pong_rdy = 1'b1;
            else ping_rdy = 1'b1;
            act_bank = ~act_bank;
            fill_cnt = '0;
            if (act_bank ? pong_rdy : ping_rdy) ovr = 1'b1;
          end
        end
      end
      ppsb_pkg::REQ_CLEAR_PING: ping_rdy = 1'b0;
      ppsb_pkg::REQ_CLEAR_PONG: pong_rdy = 1'b0;
      default: ovr = 1'b0;
    endcase
    if (ovr) r.ready_code = ppsb_pkg::RDY_OVERRUN;
    else if (ping_rdy) r.ready_code = ppsb_pkg::RDY_PING;
    else if (pong_rdy) r.ready_code = ppsb_pkg::RDY_PONG;
    else r.ready_code = ppsb_pkg::RDY_NONE;
    r.software_overrun = drop_sticky;
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: feeds requests and register writes from the stimulus queue
  always @(posedge clk) begin : drive
    logic  s_take;
    logic  cfg_take;
    logic  nxt_s;
    logic  nxt_cfg;
    logic  quiet;
    stim_t head;
    if (rst) begin
      s_tvalid    <= 1'b0;
      cfg_valid   <= 1'b0;
      smp_en      = 1'b0;
      win_size    = ppsb_pkg::WIN_SIZE_RESET;
      fill_cnt    = '0;
      act_bank    = 1'b0;
      ping_rdy    = 1'b0;
      pong_rdy    = 1'b0;
      ovr         = 1'b0;
      drop_sticky = 1'b0;
    end else begin
      s_take   = s_tvalid && s_tready;
      cfg_take = cfg_valid && cfg_ready;
      if (s_take) begin
        pending_results.push_back(steer_request(ppsb_pkg::req_t'(s_tuser), s_tdata));
        n_req++;
      end
      if (cfg_take) begin
        if (cfg_index == ppsb_pkg::CFG_SAMPLING_ENABLE) smp_en = cfg_data[0];
        else if (cfg_index == ppsb_pkg::CFG_WIN_LEN) win_size = cfg_data;
        n_cfg++;
      end
      nxt_s   = s_tvalid && !s_take;
      nxt_cfg = cfg_valid && !cfg_take;
      if (!nxt_s && !nxt_cfg && stim_q.size() != 0) begin
        head  = stim_q[0];
        quiet = (pending_results.size() == 0);
        case (head.op)
          OP_REQ: begin
            if (head.calm || $urandom_range(99) >= GAP_PCT) begin
              void'(stim_q.pop_front());
              calm_now <= head.calm;
              s_tdata  <= head.raw;
              s_tuser  <= head.kind;
              nxt_s    = 1'b1;
            end
          end
          OP_CFG: begin
            // registers change only once the block has emptied
            if (quiet) begin
              void'(stim_q.pop_front());
              cfg_index <= head.idx;
              cfg_data  <= head.val;
              nxt_cfg   = 1'b1;
            end
          end
          default: begin
            if (quiet) void'(stim_q.pop_front());
          end
        endcase
      end
      s_tvalid  <= nxt_s;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: checks each result against the oldest prediction
  always @(posedge clk) begin : watch
    ppsb_pkg::result_t got;
    ppsb_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got                  = '0;
        got.write_valid      = m_tuser;
        got.write_bank       = m_tdata[0];
        got.write_index      = m_tdata[12:1];
        got.write_sample     = m_tdata[24:13];
        got.ready_code       = ppsb_pkg::ready_code_t'(m_tdata[26:25]);
        got.sample_dropped   = m_tdata[27];
        got.software_overrun = m_tdata[28];
        n_res++;
        if (got.write_valid) n_writes++;
        if (got.sample_dropped) n_drops++;
        if (got.ready_code == ppsb_pkg::RDY_OVERRUN) n_overrun++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: data 0x%08h", m_tdata);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("write_valid", want.write_valid, got.write_valid);
          compare_field("write_bank", want.write_bank, got.write_bank);
          compare_field("write_index", want.write_index, got.write_index);
          compare_field("write_sample", want.write_sample, got.write_sample);
          compare_field("ready_code", want.ready_code, got.ready_code);
          compare_field("sample_dropped", want.sample_dropped, got.sample_dropped);
          compare_field("software_overrun", want.software_overrun, got.software_overrun);
        end
      end
      m_tready <= calm_now || ($urandom_range(99) >= GAP_PCT);
    end
  end

  task automatic add_req(ppsb_pkg::req_t kind, logic [ppsb_pkg::RAW_W-1:0] raw);
    stim_t it;
    it      = '0;
    it.op   = OP_REQ;
    it.kind = kind;
    it.raw  = raw;
    it.calm = calm_fill;
    stim_q.push_back(it);
  endtask

  task automatic add_cfg(logic [ppsb_pkg::CFG_INDEX_W-1:0] idx,
                         logic [ppsb_pkg::WIN_SIZE_W-1:0] val);
    stim_t it;
    it     = '0;
    it.op  = OP_CFG;
    it.idx = idx;
    it.val = val;
    stim_q.push_back(it);
  endtask

  task automatic add_hold();
    stim_t it;
    it    = '0;
    it.op = OP_HOLD;
    stim_q.push_back(it);
  endtask

  // Stimulus and end of run
  initial begin
    int r;
    // reset state: sampling off, request ignored; clears on empty flags
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hFFFF_FFFF);
    add_req(ppsb_pkg::REQ_CLEAR_PING, 32'h0);
    add_req(ppsb_pkg::REQ_CLEAR_PONG, 32'hFFFF_FFFF);
    add_req(ppsb_pkg::REQ_CLEAR_OVR, 32'h0);
    // one-entry windows: ping ready, pong ready with overrun, then a drop
    add_cfg(ppsb_pkg::CFG_SAMPLING_ENABLE, 13'd1);
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd1);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h0);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hFFFF_FFFF);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h5555_5555);
    add_req(ppsb_pkg::REQ_CLEAR_OVR, 32'h0);
    add_req(ppsb_pkg::REQ_CLEAR_PING, 32'h0);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hAAAA_AAAA);
    add_req(ppsb_pkg::REQ_CLEAR_PONG, 32'h0);
    add_req(ppsb_pkg::REQ_CLEAR_PING, 32'h0);
    add_req(ppsb_pkg::REQ_CLEAR_OVR, 32'h0);
    // zero-size window ignores samples
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd0);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h1234_5678);
    // sampling disabled, then a window shrunk onto the fill level
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd3);
    add_cfg(ppsb_pkg::CFG_SAMPLING_ENABLE, 13'd0);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h0000_3FFC);
    add_cfg(ppsb_pkg::CFG_SAMPLING_ENABLE, 13'd1);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h0000_3FFC);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hFFFF_C003);
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd2);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hDEAD_BEEF);
    // unknown register index has no effect
    add_cfg(4'hF, 13'h1FFF);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'hCAFE_F00D);
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd5);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h8000_0001);
    add_hold();
    add_req(ppsb_pkg::REQ_CLEAR_OVR, 32'h0);
    // finish the pong window so the random phases start on an empty ping bank
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd4);
    add_req(ppsb_pkg::REQ_SAMPLE, 32'h0000_0004);
    add_req(ppsb_pkg::REQ_CLEAR_PONG, 32'h0);
    // random phases, mostly small windows so banks turn over often
    for (int p = 0; p < 10; p++) begin
      add_cfg(ppsb_pkg::CFG_SAMPLING_ENABLE, ($urandom_range(9) == 0) ? 13'd0 : 13'd1);
      r = $urandom_range(19);
      if (r == 0) add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd0);
      else if (r == 1) add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'($urandom_range(4097, 8191)));
      else add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'($urandom_range(1, 6)));
      calm_fill = (p == 3);
      for (int i = 0; i < 36; i++) begin
        if (p == 5 && i == 20) add_hold();
        if ($urandom_range(99) < 60) add_req(ppsb_pkg::REQ_SAMPLE, $urandom);
        else add_req(ppsb_pkg::req_t'($urandom_range(1, 3)), $urandom);
      end
    end
    calm_fill = 1'b0;
    // full-size window, then an oversized setting that saturates
    add_cfg(ppsb_pkg::CFG_SAMPLING_ENABLE, 13'd1);
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'd4096);
    add_req(ppsb_pkg::REQ_CLEAR_PING, 32'h0);
    add_req(ppsb_pkg::REQ_CLEAR_PONG, 32'h0);
    for (int i = 0; i < 10; i++) add_req(ppsb_pkg::REQ_SAMPLE, $urandom);
    add_cfg(ppsb_pkg::CFG_WIN_LEN, 13'h1FFF);
    for (int i = 0; i < 10; i++) add_req(ppsb_pkg::REQ_SAMPLE, $urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (stim_q.size() != 0 || s_tvalid || cfg_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Run covered %0d requests and %0d register writes; %0d results checked.",
             n_req, n_cfg, n_res);
    $display("Results seen: %0d memory writes, %0d dropped samples, %0d with overrun.",
             n_writes, n_drops, n_overrun);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
